@@ hw/rtl/latency_occupancy_spike_detector_core_macros.svh @@
// ----------------------------------------------------------------------------
// Spike detector assertion macros
// Shared concurrent assertion shorthands for the spike detector.
// ----------------------------------------------------------------------------
`ifndef LATENCY_OCCUPANCY_SPIKE_DETECTOR_CORE_MACROS_SVH
`define LATENCY_OCCUPANCY_SPIKE_DETECTOR_CORE_MACROS_SVH

// same-cycle implication
`define LOSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spike detector check failed");

// next-cycle implication
`define LOSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spike detector check failed");

`endif

@@ hw/rtl/losd_pkg.sv @@
// ----------------------------------------------------------------------------
// Spike detector package
// Beat types, register indexes, codes and a helper for the spike detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package losd_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LATENCY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_LIMIT     = 2'd1;

  localparam logic [14:0] LAT_LIMIT_RST = 15'd60;
  localparam logic [4:0]  OCC_LIMIT_RST = 5'd10;
  localparam logic [4:0]  OCC_NA        = 5'd31;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam logic [1:0] RK_LATENCY   = 2'd0;
  localparam logic [1:0] RK_OCCUPANCY = 2'd1;
  localparam logic [1:0] RK_ORDER_ERR = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [31:0]        packet_number;
    logic [41:0]        send_time_ms;
    logic signed [15:0] latency_ms;
    logic [4:0]         occupancy;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         record_kind;
    logic [4:0]         peak_occupancy;
    logic [31:0]        first_packet;
    logic [31:0]        final_packet;
    logic [31:0]        span_ms;
    logic signed [15:0] peak_latency_ms;
    logic [31:0]        peak_latency_packet;
    logic               run_end;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_beat_t;

  // later - earlier, zero if not positive, saturated to 32 bits
  function automatic logic [31:0] span_of(input logic [41:0] later,
                                          input logic [41:0] earlier);
    logic [41:0] d;
    d = later - earlier;
    if (later <= earlier) begin
      return 32'd0;
    end else if (d[41:32] != 10'd0) begin
      return 32'hFFFF_FFFF;
    end else begin
      return d[31:0];
    end
  endfunction

endpackage

@@ hw/rtl/losd_stream_if.sv @@
// ----------------------------------------------------------------------------
// Spike detector stream interface
// Valid/ready channel carrying one beat of a chosen payload type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface losd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/latency_occupancy_spike_detector_core.sv @@
// ----------------------------------------------------------------------------
// Latency and occupancy spike detector
// Two threshold run detectors over a packet record stream, with order-error records.
// ----------------------------------------------------------------------------
// in_i takes packet or flush beats (losd_pkg::in_beat_t); out_o delivers run
// records (losd_pkg::out_beat_t); cfg_i writes the latency and occupancy
// limits and is always ready.
// An input beat is evaluated in the cycle it is accepted; its zero, one or two
// records are registered into a small result queue that drives out_o.
// A packet or flush beat is accepted every cycle while the queue has room for
// two records (Depth - 2 or fewer entries held), so the rate is one beat per
// cycle, bounded over time by the sink taking records: one record per cycle.
// When the sink stalls, records wait in the queue and in_i.ready drops once
// fewer than two slots are free.
// Reset clears all run state, empties the queue and loads the default limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "latency_occupancy_spike_detector_core_macros.svh"

module latency_occupancy_spike_detector_core #(
  parameter int unsigned Depth = losd_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  losd_stream_if.sink   in_i,
  losd_stream_if.sink   cfg_i,
  losd_stream_if.source out_o
);

  localparam int unsigned PtrW = (Depth > 2) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [14:0]        lat_limit_q;
  logic [4:0]         occ_limit_q;

  logic               lat_active_q;
  logic [4:0]         lat_peak_occ_q;
  logic signed [15:0] lat_peak_q;
  logic [31:0]        lat_peak_pkt_q;
  logic [31:0]        lat_first_q;
  logic [41:0]        lat_start_q;
  logic               occ_active_q;
  logic [4:0]         occ_peak_q;
  logic [31:0]        occ_first_q;
  logic [41:0]        occ_start_q;
  logic [41:0]        prev_time_q;
  logic [4:0]         prev_occ_q;
  logic [31:0]        prev_pkt_q;

  losd_pkg::out_beat_t fifo_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q, wr_nxt, wr_nxt2, rd_nxt;
  logic [CntW-1:0]     count_q, count_d;

  losd_pkg::in_beat_t  ib;
  losd_pkg::out_beat_t lat_rec, occ_rec, err_rec, rec0;
  logic                acc, pop, flush, err, lat_hi, occ_hi, lat_close, occ_close;
  logic [4:0]          occ_eff;
  logic [41:0]         end_time;
  logic [1:0]          n_push;

  assign ib    = in_i.data;
  assign acc   = in_i.valid && in_i.ready;
  assign pop   = out_o.valid && out_o.ready;
  assign cfg_i.ready = 1'b1;

  assign in_i.ready  = (count_q <= CntW'(Depth - 2));
  assign out_o.valid = (count_q != '0);
  assign out_o.data  = fifo_q[rd_ptr_q];

  // beat evaluation
  always_comb begin
    flush     = (ib.kind == losd_pkg::KIND_FLUSH);
    err       = !flush && (ib.send_time_ms < prev_time_q);
    occ_eff   = (ib.occupancy == losd_pkg::OCC_NA) ? prev_occ_q : ib.occupancy;
    lat_hi    = ib.latency_ms > $signed({1'b0, lat_limit_q});
    occ_hi    = occ_eff > occ_limit_q;
    lat_close = lat_active_q && (flush || (!err && !lat_hi));
    occ_close = occ_active_q && (flush || (!err && !occ_hi));
    end_time  = flush ? prev_time_q : ib.send_time_ms;

    lat_rec.record_kind         = losd_pkg::RK_LATENCY;
    lat_rec.peak_occupancy      = lat_peak_occ_q;
    lat_rec.first_packet        = lat_first_q;
    lat_rec.final_packet        = prev_pkt_q;
    lat_rec.span_ms             = losd_pkg::span_of(end_time, lat_start_q);
    lat_rec.peak_latency_ms     = lat_peak_q;
    lat_rec.peak_latency_packet = lat_peak_pkt_q;
    lat_rec.run_end             = !occ_close;

    occ_rec.record_kind         = losd_pkg::RK_OCCUPANCY;
    occ_rec.peak_occupancy      = occ_peak_q;
    occ_rec.first_packet        = occ_first_q;
    occ_rec.final_packet        = prev_pkt_q;
    occ_rec.span_ms             = losd_pkg::span_of(end_time, occ_start_q);
    occ_rec.peak_latency_ms     = '0;
    occ_rec.peak_latency_packet = '0;
    occ_rec.run_end             = 1'b1;

    err_rec.record_kind         = losd_pkg::RK_ORDER_ERR;
    err_rec.peak_occupancy      = '0;
    err_rec.first_packet        = ib.packet_number;
    err_rec.final_packet        = ib.packet_number;
    err_rec.span_ms             = '0;
    err_rec.peak_latency_ms     = '0;
    err_rec.peak_latency_packet = '0;
    err_rec.run_end             = 1'b1;

    if (err) begin
      rec0 = err_rec;
    end else if (lat_close) begin
      rec0 = lat_rec;
    end else begin
      rec0 = occ_rec;
    end

    if (!acc) begin
      n_push = 2'd0;
    end else if (err) begin
      n_push = 2'd1;
    end else begin
      n_push = {1'b0, lat_close} + {1'b0, occ_close};
    end
  end

  // queue pointers
  always_comb begin
    wr_nxt  = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    wr_nxt2 = (wr_nxt == PtrW'(Depth - 1)) ? '0 : wr_nxt + 1'b1;
    rd_nxt  = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    count_d = count_q + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= rec0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_nxt] <= occ_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (pop) begin
        rd_ptr_q <= rd_nxt;
      end
      case (n_push)
        2'd1:    wr_ptr_q <= wr_nxt;
        2'd2:    wr_ptr_q <= wr_nxt2;
        default: wr_ptr_q <= wr_ptr_q;
      endcase
    end
  end

  // limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_limit_q <= losd_pkg::LAT_LIMIT_RST;
      occ_limit_q <= losd_pkg::OCC_LIMIT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        losd_pkg::REG_LATENCY_LIMIT: lat_limit_q <= cfg_i.data.wdata[14:0];
        losd_pkg::REG_OCC_LIMIT:     occ_limit_q <= cfg_i.data.wdata[4:0];
        default:                     lat_limit_q <= lat_limit_q;
      endcase
    end
  end

  // run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_active_q   <= 1'b0;
      lat_peak_occ_q <= '0;
      lat_peak_q     <= '0;
      lat_peak_pkt_q <= '0;
      lat_first_q    <= '0;
      lat_start_q    <= '0;
      occ_active_q   <= 1'b0;
      occ_peak_q     <= '0;
      occ_first_q    <= '0;
      occ_start_q    <= '0;
      prev_time_q    <= '0;
      prev_occ_q     <= '0;
      prev_pkt_q     <= '0;
    end else if (acc && flush) begin
      lat_active_q <= 1'b0;
      occ_active_q <= 1'b0;
      prev_time_q  <= '0;
      prev_occ_q   <= '0;
      prev_pkt_q   <= '0;
    end else if (acc && !err) begin
      if (lat_hi) begin
        if (!lat_active_q) begin
          lat_active_q   <= 1'b1;
          lat_peak_occ_q <= occ_eff;
          lat_peak_q     <= ib.latency_ms;
          lat_peak_pkt_q <= ib.packet_number;
          lat_first_q    <= ib.packet_number;
          lat_start_q    <= ib.send_time_ms;
        end else begin
          if (occ_eff > lat_peak_occ_q) begin
            lat_peak_occ_q <= occ_eff;
          end
          if (ib.latency_ms > lat_peak_q) begin
            lat_peak_q     <= ib.latency_ms;
            lat_peak_pkt_q <= ib.packet_number;
          end
        end
      end else begin
        lat_active_q <= 1'b0;
      end
      if (occ_hi) begin
        if (!occ_active_q) begin
          occ_active_q <= 1'b1;
          occ_peak_q   <= occ_eff;
          occ_first_q  <= ib.packet_number;
          occ_start_q  <= ib.send_time_ms;
        end else if (occ_eff > occ_peak_q) begin
          occ_peak_q <= occ_eff;
        end
      end else begin
        occ_active_q <= 1'b0;
      end
      prev_time_q <= ib.send_time_ms;
      prev_occ_q  <= occ_eff;
      prev_pkt_q  <= ib.packet_number;
    end
  end

  `LOSD_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Depth))
  `LOSD_ASSERT_NEXT(a_err_queued, clk_i, rst_ni, acc && err, count_q != '0)
  `LOSD_ASSERT_NEXT(a_flush_clears, clk_i, rst_ni, acc && flush, !lat_active_q && !occ_active_q)

endmodule
